// ----- sv/rpbu_pkg.sv -----
// Package for the RGB pixel blend unit: field widths, blend codes, register
// indexes and the per-stage pipeline records.
// No dependencies; every module of the block imports it.
package rpbu_pkg;

    localparam int CHANNELS    = 3;
    localparam int PIX_W       = 8;
    localparam int OFFSET_W    = 9;
    localparam int FUNC_W      = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;
    localparam int IN_DATA_W   = 2 * CHANNELS * PIX_W;
    localparam int OUT_DATA_W  = CHANNELS * PIX_W;
    localparam int PROD_W      = 2 * PIX_W + 1;
    localparam int BIASED_W    = PROD_W + 1;
    localparam int RECIP_W     = 17;
    localparam int QPROD_W     = BIASED_W + RECIP_W;
    localparam int QUOT_LSB    = 24;

    // floor((x + 127) / 255) == ((x + 128) * 65793) >> 24 for x below 2^17
    localparam logic [RECIP_W-1:0]  RECIP_255  = 17'd65793;
    localparam logic [BIASED_W-1:0] ROUND_BIAS = 18'd128;
    localparam logic [PIX_W-1:0]    PIX_MAX    = 8'd255;

    // blend codes
    localparam logic [FUNC_W-1:0] FUNC_MULTIPLY = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUBTRACT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SCREEN   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_OVERLAY  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_ADD      = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_SCALE    = 3'd5;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_BLUE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_GREEN = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_RED   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACTOR_BLUE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACTOR_GREEN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACTOR_RED   = 3'd5;

    // how the last stage forms a channel
    typedef logic [1:0] rpbu_kind_t;
    localparam rpbu_kind_t KIND_DIRECT    = 2'd0;
    localparam rpbu_kind_t KIND_ROUND     = 2'd1;
    localparam rpbu_kind_t KIND_ROUND_INV = 2'd2;
    localparam rpbu_kind_t KIND_SAT       = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] m1;
        logic [PIX_W-1:0] m2;
        logic             dbl;
        rpbu_kind_t       kind;
        logic [PIX_W-1:0] direct;
    } rpbu_s1_t;

    typedef struct packed {
        logic [PROD_W-1:0] prod;
        rpbu_kind_t        kind;
        logic [PIX_W-1:0]  direct;
    } rpbu_s2_t;

    typedef struct packed {
        logic [PIX_W-1:0] quot;
        rpbu_kind_t       kind;
        logic [PIX_W-1:0] direct;
    } rpbu_s3_t;

endpackage

// ----- sv/rgb_pixel_blend_unit_core.sv -----
// Top level of the RGB pixel blend unit: four-stage per-channel blend pipeline
// and the six configuration registers.
// Depends on rpbu_pkg.
//
// Usage:
//   s_tvalid/s_tready/s_tdata/s_tuser carry one request: a pixel pair (top A,
//   bottom B) in tdata and the blend code in tuser. m_tvalid/m_tready/m_tdata
//   return the blended pixel, one per request, in order.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the offsets (index 0..2) and
//   the scale factors (index 3..5); writes to other indexes are dropped.
//   Write configuration only while no request is in flight.
// Throughput: one request per cycle while m_tready stays high; the stages are
//   operand select, 8x8 product, reciprocal multiply for the divide by 255,
//   and the output register.
// Reset: empties the pipeline, offsets go to 0 and factors to 1.
// Stall: with m_tready low each stage holds once the stage after it is full;
//   s_tready falls only when all four stages hold a request.
module rgb_pixel_blend_unit_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // a_blue, a_green, a_red, b_blue, b_green, b_red (8 bits each, from bit 0)
    input  logic [rpbu_pkg::IN_DATA_W-1:0]     s_tdata,
    // func (3 bits)
    input  logic [rpbu_pkg::FUNC_W-1:0]        s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_blue, out_green, out_red (8 bits each, from bit 0)
    output logic [rpbu_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rpbu_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rpbu_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rpbu_pkg::*;

    localparam int B_BASE = CHANNELS * PIX_W;

    logic [OFFSET_W-1:0] offset_reg [CHANNELS];
    logic [PIX_W-1:0]    factor_reg [CHANNELS];

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    rpbu_s1_t s1_reg  [CHANNELS];
    rpbu_s1_t s1_next [CHANNELS];
    rpbu_s2_t s2_reg  [CHANNELS];
    rpbu_s2_t s2_next [CHANNELS];
    rpbu_s3_t s3_reg  [CHANNELS];
    rpbu_s3_t s3_next [CHANNELS];
    logic [OUT_DATA_W-1:0] out_reg, out_next;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                offset_reg[i] <= '0;
                factor_reg[i] <= PIX_W'(1);
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_OFFSET_BLUE:  offset_reg[0] <= cfg_data;
                CFG_OFFSET_GREEN: offset_reg[1] <= cfg_data;
                CFG_OFFSET_RED:   offset_reg[2] <= cfg_data;
                CFG_FACTOR_BLUE:  factor_reg[0] <= cfg_data[PIX_W-1:0];
                CFG_FACTOR_GREEN: factor_reg[1] <= cfg_data[PIX_W-1:0];
                CFG_FACTOR_RED:   factor_reg[2] <= cfg_data[PIX_W-1:0];
                default:          ;
            endcase
        end
    end

    // a stage advances when it is empty or the next one advances
    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage 1: pick the multiplier operands or form the result directly
    always_comb
    begin
        logic [PIX_W-1:0] a, b, ia, ib;
        logic signed [OFFSET_W:0] sum;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            a   = s_tdata[ch*PIX_W +: PIX_W];
            b   = s_tdata[B_BASE + ch*PIX_W +: PIX_W];
            ia  = PIX_MAX - a;
            ib  = PIX_MAX - b;
            sum = $signed({2'b00, a}) + $signed({offset_reg[ch][OFFSET_W-1], offset_reg[ch]});
            s1_next[ch].m1     = a;
            s1_next[ch].m2     = b;
            s1_next[ch].dbl    = 1'b0;
            s1_next[ch].kind   = KIND_DIRECT;
            s1_next[ch].direct = '0;
            unique case (s_tuser)
                FUNC_MULTIPLY:
                    s1_next[ch].kind = KIND_ROUND;
                FUNC_SUBTRACT:
                    s1_next[ch].direct = (a > b) ? a - b : '0;
                FUNC_SCREEN:
                begin
                    s1_next[ch].m1   = ia;
                    s1_next[ch].m2   = ib;
                    s1_next[ch].kind = KIND_ROUND_INV;
                end
                FUNC_OVERLAY:
                begin
                    s1_next[ch].dbl = 1'b1;
                    if (b[PIX_W-1])
                    begin
                        s1_next[ch].m1   = ia;
                        s1_next[ch].m2   = ib;
                        s1_next[ch].kind = KIND_ROUND_INV;
                    end
                    else
                        s1_next[ch].kind = KIND_ROUND;
                end
                FUNC_ADD:
                begin
                    // clamp to 0..255
                    if (sum[OFFSET_W])
                        s1_next[ch].direct = '0;
                    else if (sum[OFFSET_W-1])
                        s1_next[ch].direct = PIX_MAX;
                    else
                        s1_next[ch].direct = sum[PIX_W-1:0];
                end
                FUNC_SCALE:
                begin
                    s1_next[ch].m2   = factor_reg[ch];
                    s1_next[ch].kind = KIND_SAT;
                end
                default:
                    s1_next[ch].direct = '0;
            endcase
        end
    end

    // stage 2: 8x8 product, doubled for overlay
    always_comb
    begin
        logic [2*PIX_W-1:0] p;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            p = s1_reg[ch].m1 * s1_reg[ch].m2;
            s2_next[ch].prod   = s1_reg[ch].dbl ? {p, 1'b0} : {1'b0, p};
            s2_next[ch].kind   = s1_reg[ch].kind;
            s2_next[ch].direct = s1_reg[ch].direct;
        end
    end

    // stage 3: divide by 255 with rounding through a reciprocal multiply;
    // resolve scale saturation here as well
    always_comb
    begin
        logic [BIASED_W-1:0] z;
        logic [QPROD_W-1:0]  qp;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            z  = {1'b0, s2_reg[ch].prod} + ROUND_BIAS;
            qp = z * RECIP_255;
            s3_next[ch].quot   = qp[QUOT_LSB +: PIX_W];
            s3_next[ch].kind   = s2_reg[ch].kind;
            s3_next[ch].direct = s2_reg[ch].direct;
            if (s2_reg[ch].kind == KIND_SAT)
            begin
                s3_next[ch].kind   = KIND_DIRECT;
                s3_next[ch].direct = (s2_reg[ch].prod[PROD_W-1:PIX_W] != '0)
                                   ? PIX_MAX : s2_reg[ch].prod[PIX_W-1:0];
            end
        end
    end

    // stage 4: final select into the output register
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            unique case (s3_reg[ch].kind)
                KIND_ROUND:     out_next[ch*PIX_W +: PIX_W] = s3_reg[ch].quot;
                KIND_ROUND_INV: out_next[ch*PIX_W +: PIX_W] = PIX_MAX - s3_reg[ch].quot;
                default:        out_next[ch*PIX_W +: PIX_W] = s3_reg[ch].direct;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1) s1_reg  <= s1_next;
        if (en2) s2_reg  <= s2_next;
        if (en3) s3_reg  <= s3_next;
        if (en4) out_reg <= out_next;
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = out_reg;

endmodule

// ----- sv/rpbu_checker.sv -----
// Port-level checker for the RGB pixel blend unit, bound to the top level.
// Depends on rpbu_pkg and rgb_pixel_blend_unit_core.
module rpbu_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [rpbu_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                             cfg_valid,
    input logic                             cfg_ready
);
    import rpbu_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result dropped or changed");

    // an empty output stage means the whole pipe can advance
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // an accepted request reaches the output when the receiver keeps taking results
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready
        |=> m_tvalid)
        else $error("request did not reach the output in four cycles");

    // configuration writes are never refused
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind rgb_pixel_blend_unit_core rpbu_checker u_rpbu_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

// ----- tb/tb_rgb_pixel_blend_unit_core.sv -----
// Self-checking testbench for rgb_pixel_blend_unit_core: drives pixel pairs and
// register writes, predicts every blended pixel and checks the output stream.
// Depends on rpbu_pkg and rgb_pixel_blend_unit_core.
`timescale 1ns / 100ps

module tb_rgb_pixel_blend_unit_core;

    import rpbu_pkg::*;

    localparam int PIPE_DEPTH  = 4;
    localparam int LONG_HOLD   = 60;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 230;

    // codes the block must treat as unused
    localparam logic [FUNC_W-1:0]      FUNC_SPARE_LO  = 3'd6;
    localparam logic [FUNC_W-1:0]      FUNC_SPARE_HI  = 3'd7;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI   = 3'd7;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    class blend_scoreboard;
        logic signed [OFFSET_W-1:0] offset[CHANNELS];
        logic [PIX_W-1:0]           factor[CHANNELS];
        pixel_t                     expected_q[$];
        int                         failures;

        function new();
            for (int i = 0; i < CHANNELS; i++)
            begin
                offset[i] = '0;
                factor[i] = 8'd1;
            end
            failures = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_OFFSET_BLUE:  offset[0] = data;
                CFG_OFFSET_GREEN: offset[1] = data;
                CFG_OFFSET_RED:   offset[2] = data;
                CFG_FACTOR_BLUE:  factor[0] = data[PIX_W-1:0];
                CFG_FACTOR_GREEN: factor[1] = data[PIX_W-1:0];
                CFG_FACTOR_RED:   factor[2] = data[PIX_W-1:0];
                default: ;
            endcase
        endfunction

        function int round255(int x);
            return (x + 127) / 255;
        endfunction

        function logic [PIX_W-1:0] blend_channel(logic [FUNC_W-1:0] func,
                                                 logic [PIX_W-1:0] a,
                                                 logic [PIX_W-1:0] b, int ch);
            int ai;
            int bi;
            int s;
            ai = int'(a);
            bi = int'(b);
            case (func)
                FUNC_MULTIPLY: return PIX_W'(round255(ai * bi));
                FUNC_SUBTRACT: return PIX_W'((ai > bi) ? ai - bi : 0);
                FUNC_SCREEN:   return PIX_W'(255 - round255((255 - ai) * (255 - bi)));
                FUNC_OVERLAY:
                begin
                    if (bi <= 127)
                        return PIX_W'(round255(2 * ai * bi));
                    return PIX_W'(255 - round255(2 * (255 - ai) * (255 - bi)));
                end
                FUNC_ADD:
                begin
                    s = ai + int'(offset[ch]);
                    if (s < 0)
                        s = 0;
                    if (s > 255)
                        s = 255;
                    return PIX_W'(s);
                end
                FUNC_SCALE:
                begin
                    s = ai * int'(factor[ch]);
                    return PIX_W'((s > 255) ? 255 : s);
                end
                default: return '0;
            endcase
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic [IN_DATA_W-1:0] pix);
            pixel_t p;
            p.blue  = blend_channel(func, pix[7:0],   pix[31:24], 0);
            p.green = blend_channel(func, pix[15:8],  pix[39:32], 1);
            p.red   = blend_channel(func, pix[23:16], pix[47:40], 2);
            expected_q = {expected_q, p};
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            failures++;
        endtask

        task check_pixel(logic [OUT_DATA_W-1:0] got_bits);
            pixel_t want;
            pixel_t got;
            got = got_bits;
            if (expected_q.size() == 0)
            begin
                report($sformatf("pixel %h with no request outstanding", got_bits));
                return;
            end
            want = expected_q.pop_front();
            if (got.blue !== want.blue)
                report($sformatf("out_blue got %0d want %0d", got.blue, want.blue));
            if (got.green !== want.green)
                report($sformatf("out_green got %0d want %0d", got.green, want.green));
            if (got.red !== want.red)
                report($sformatf("out_red got %0d want %0d", got.red, want.red));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic [FUNC_W-1:0]      s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int hold_left      = 0;

    blend_scoreboard sb = new();

    rgb_pixel_blend_unit_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // sample every handshake at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                sb.check_pixel(m_tdata);
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic offer_pixel(input logic [FUNC_W-1:0] func, input logic [IN_DATA_W-1:0] pix);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= pix;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // hold the input until every outstanding pixel has come back
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 2) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 62;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 62;
            end
            default:
            begin
                send_idle_pct  = 11;
                recv_stall_pct = 11;
            end
        endcase
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_offset();
        case ($urandom_range(5))
            0: return 9'h100;
            1: return 9'h101;
            2: return 9'h0FF;
            3: return 9'h000;
            4: return 9'h1FF;
            default: return CFG_DATA_W'($urandom_range(511));
        endcase
    endfunction

    // bit 8 is don't-care for a factor, so toggle it too
    function automatic logic [CFG_DATA_W-1:0] pick_factor();
        logic [PIX_W-1:0] f;
        case ($urandom_range(4))
            0: f = 8'd0;
            1: f = 8'd1;
            2: f = 8'd255;
            default: f = PIX_W'($urandom_range(255));
        endcase
        return {1'($urandom_range(1)), f};
    endfunction

    function automatic logic [PIX_W-1:0] pick_channel();
        if ($urandom_range(7) == 0)
        begin
            case ($urandom_range(3))
                0: return 8'd0;
                1: return 8'd255;
                2: return 8'd127;
                default: return 8'd128;
            endcase
        end
        return PIX_W'($urandom_range(255));
    endfunction

    function automatic logic [FUNC_W-1:0] pick_func();
        if ($urandom_range(15) == 0)
            return $urandom_range(1) ? FUNC_SPARE_HI : FUNC_SPARE_LO;
        case ($urandom_range(5))
            0: return FUNC_MULTIPLY;
            1: return FUNC_SUBTRACT;
            2: return FUNC_SCREEN;
            3: return FUNC_OVERLAY;
            4: return FUNC_ADD;
            default: return FUNC_SCALE;
        endcase
    endfunction

    initial
    begin
        logic [IN_DATA_W-1:0] pix;
        logic [FUNC_W-1:0]    func;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values: unit gain, zero offset
        offer_pixel(FUNC_ADD,   {6{8'd255}});
        offer_pixel(FUNC_SCALE, {6{8'd255}});
        drain_pipe();

        // extreme register values, then writes that must be dropped
        write_cfg(CFG_OFFSET_BLUE,  9'h100);
        write_cfg(CFG_OFFSET_GREEN, 9'h0FF);
        write_cfg(CFG_OFFSET_RED,   9'h101);
        write_cfg(CFG_FACTOR_BLUE,  9'h000);
        write_cfg(CFG_FACTOR_GREEN, 9'h0FF);
        write_cfg(CFG_FACTOR_RED,   9'h102);
        write_cfg(CFG_SPARE_LO,     9'h1FF);
        write_cfg(CFG_SPARE_HI,     9'h155);

        // every blend code on zero, full-scale and overlay threshold operands
        for (int f = 0; f < 8; f++)
        begin
            func = FUNC_W'(f);
            offer_pixel(func, '0);
            offer_pixel(func, '1);
            offer_pixel(func, {8'd128, 8'd127, 8'd255, 8'd200, 8'd255, 8'd0});
        end
        drain_pipe();

        for (int p = 0; p < PHASES; p++)
        begin
            write_cfg(CFG_OFFSET_BLUE,  pick_offset());
            write_cfg(CFG_OFFSET_GREEN, pick_offset());
            write_cfg(CFG_OFFSET_RED,   pick_offset());
            write_cfg(CFG_FACTOR_BLUE,  pick_factor());
            write_cfg(CFG_FACTOR_GREEN, pick_factor());
            write_cfg(CFG_FACTOR_RED,   pick_factor());
            set_idling(p % 4);
            // back-pressure with a saturating sender fills the pipeline
            if (p % 4 == 0)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                for (int c = 0; c < 2 * CHANNELS; c++)
                    pix[c*PIX_W +: PIX_W] = pick_channel();
                offer_pixel(pick_func(), pix);
            end
            drain_pipe();
        end

        repeat (PIPE_DEPTH * 4) @(negedge clk);
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
